/* design/linear_octree_query_engine_defines.svh */
// assertion macros for the linear octree query engine
// used at the end of the top level, needs clk and rst in scope
`ifndef LINEAR_OCTREE_QUERY_ENGINE_DEFINES_SVH
`define LINEAR_OCTREE_QUERY_ENGINE_DEFINES_SVH

// same-cycle implication
`define LOQE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LOQE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* design/loqe_pkg.sv */
// constants, request codes and key helper functions for the octree query engine
// used by linear_octree_query_engine, no dependencies
package loqe_pkg;

  localparam int MAX_ENTRIES_DEF  = 1024;
  localparam int DIMENSIONS       = 3;
  localparam int PATH_BITS        = 60;
  localparam int LEVEL_FIELD_BITS = 4;

  localparam int KW  = 64;
  localparam int LW  = LEVEL_FIELD_BITS;
  localparam int SW  = DIMENSIONS;
  localparam int SHW = $clog2(PATH_BITS + 1);
  localparam int IW  = 11;
  localparam int XW  = 10;

  localparam logic [SW-1:0] SLOT_MAX = {SW{1'b1}};

  localparam logic [1:0] REQ_LOAD     = 2'd0;
  localparam logic [1:0] REQ_CHILDREN = 2'd1;
  localparam logic [1:0] REQ_SIBLINGS = 2'd2;
  localparam logic [1:0] REQ_SUBTREE  = 2'd3;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_RANGE = 2'd1;
  localparam logic [1:0] STAT_ROOT  = 2'd2;

  typedef logic [KW-1:0] key_t;
  typedef logic [LW-1:0] lvl_t;

  function automatic lvl_t lvl_of(key_t k);
    return k[LW-1:0];
  endfunction

  function automatic key_t path_of(key_t k);
    return k >> LW;
  endfunction

  function automatic logic [SHW-1:0] shift_at(lvl_t l);
    int b;
    b = int'(l) * DIMENSIONS;
    return (b >= PATH_BITS) ? '0 : SHW'(PATH_BITS - b);
  endfunction

  function automatic key_t make_key(key_t p, lvl_t l);
    return (p << LW) | key_t'(l);
  endfunction

  function automatic logic [SW-1:0] slot_of(key_t k);
    key_t sh;
    sh = path_of(k) >> shift_at(lvl_of(k));
    return (lvl_of(k) == '0) ? '0 : sh[SW-1:0];
  endfunction

  function automatic logic has_next(key_t k);
    return (lvl_of(k) != '0) && (slot_of(k) != SLOT_MAX);
  endfunction

  function automatic key_t next_sib(key_t k);
    logic [SHW-1:0] sh;
    logic [SW-1:0] ns;
    key_t p;
    sh = shift_at(lvl_of(k));
    ns = slot_of(k) + 1'b1;
    p = path_of(k) & ~(key_t'(SLOT_MAX) << sh);
    p = p | (key_t'(ns) << sh);
    return make_key(p, lvl_of(k));
  endfunction

  function automatic key_t parent_key(key_t k);
    lvl_t pl;
    logic [SHW-1:0] sh;
    pl = (lvl_of(k) != '0) ? lvl_of(k) - 1'b1 : '0;
    sh = shift_at(pl);
    return make_key((path_of(k) >> sh) << sh, pl);
  endfunction

  function automatic logic is_anc(key_t a, key_t d);
    return (lvl_of(a) < lvl_of(d)) &&
           (((path_of(a) ^ path_of(d)) >> shift_at(lvl_of(a))) == '0);
  endfunction

endpackage

/* design/linear_octree_query_engine.sv */
// linear octree query engine: key store memory, binary search sequencer, result register
// depends on loqe_pkg and linear_octree_query_engine_defines.svh
// load gives no result; a range error is registered straight from idle, a root error after the dispatch state
// each search probe is one key store read, through a search state and then a compare state
// children runs up to 7 searches, siblings up to 8 (one more for the parent)
// subtree walks one search per sibling tried; one request at a time; reset clears control only
`include "linear_octree_query_engine_defines.svh"

module linear_octree_query_engine (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [10:0]                 cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  req_type,
  input  logic [9:0]                  entry_index,
  input  logic [63:0]                 key_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [loqe_pkg::SW-1:0]     slot,
  output logic                        found,
  output logic [loqe_pkg::XW-1:0]     result_index,
  output logic [loqe_pkg::XW-1:0]     subtree_count,
  output logic [1:0]                  status,
  output logic                        last
);

  localparam int MAX_ENTRIES = loqe_pkg::MAX_ENTRIES_DEF;
  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int IW = loqe_pkg::IW;
  localparam int SW = loqe_pkg::SW;
  localparam int XW = loqe_pkg::XW;

  localparam logic [4:0] ST_IDLE     = 5'd0;
  localparam logic [4:0] ST_DISPATCH = 5'd1;
  localparam logic [4:0] ST_CH_START = 5'd2;
  localparam logic [4:0] ST_CH_CHK   = 5'd3;
  localparam logic [4:0] ST_SIB_PAR  = 5'd4;
  localparam logic [4:0] ST_SIB_RDP  = 5'd5;
  localparam logic [4:0] ST_EMIT     = 5'd6;
  localparam logic [4:0] ST_EMIT_R   = 5'd7;
  localparam logic [4:0] ST_OUT      = 5'd8;
  localparam logic [4:0] ST_CHKN     = 5'd9;
  localparam logic [4:0] ST_WALK     = 5'd10;
  localparam logic [4:0] ST_WALK_R   = 5'd11;
  localparam logic [4:0] ST_SRCH     = 5'd12;
  localparam logic [4:0] ST_SCMP     = 5'd13;

  logic [63:0] mem [MAX_ENTRIES];
  logic [63:0] rdata;
  logic [AW-1:0] raddr;
  logic mem_we;

  logic [4:0] state, state_next, ret, ret_next;
  logic [1:0] req, req_next;
  logic [XW-1:0] qidx, qidx_next;
  logic [IW-1:0] n, n_next, base, base_next;
  logic [IW-1:0] lo, lo_next, hi, hi_next, mid, mid_next, s_idx, s_idx_next;
  logic s_found, s_found_next;
  loqe_pkg::key_t cur_key, cur_key_next, needle, needle_next;
  logic [SW-1:0] s0, s0_next, slot_cnt, slot_cnt_next;
  logic all_miss, all_miss_next;
  logic [IW-1:0] eiu;
  logic [IW-1:0] nmin;

  logic out_valid_next, found_next, last_next;
  logic [SW-1:0] slot_next;
  logic [XW-1:0] result_index_next, subtree_count_next;
  logic [1:0] status_next;

  logic [IW-1:0] c_idx, qp1, cnt_tail;
  loqe_pkg::key_t sib_key;

  assign in_ready = (state == ST_IDLE) && !out_valid;
  assign nmin = (32'(eiu) > MAX_ENTRIES) ? IW'(MAX_ENTRIES) : eiu;
  assign c_idx = base + 1'b1;
  assign qp1 = IW'(qidx) + 1'b1;
  assign cnt_tail = n - IW'(qidx) - 1'b1;
  assign sib_key = loqe_pkg::next_sib(cur_key);
  assign mem_we = in_valid && in_ready && (req_type == loqe_pkg::REQ_LOAD) &&
                  (32'(entry_index) < MAX_ENTRIES);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[AW'(entry_index)] <= key_value;
    end
    rdata <= mem[raddr];
  end

  always_comb begin
    state_next = state;
    ret_next = ret;
    req_next = req;
    qidx_next = qidx;
    n_next = n;
    base_next = base;
    lo_next = lo;
    hi_next = hi;
    mid_next = mid;
    s_idx_next = s_idx;
    s_found_next = s_found;
    cur_key_next = cur_key;
    needle_next = needle;
    s0_next = s0;
    slot_cnt_next = slot_cnt;
    all_miss_next = all_miss;
    out_valid_next = out_valid;
    slot_next = slot;
    found_next = found;
    result_index_next = result_index;
    subtree_count_next = subtree_count;
    status_next = status;
    last_next = last;
    raddr = AW'(qidx);

    unique case (state)
      ST_IDLE: begin
        raddr = AW'(entry_index);
        if (in_valid && in_ready) begin
          req_next = req_type;
          qidx_next = entry_index;
          n_next = nmin;
          if (req_type == loqe_pkg::REQ_LOAD) begin
            state_next = ST_IDLE;
          end else if (IW'(entry_index) >= nmin) begin
            out_valid_next = 1'b1;
            slot_next = '0;
            found_next = 1'b0;
            result_index_next = '0;
            subtree_count_next = '0;
            status_next = loqe_pkg::STAT_RANGE;
            last_next = 1'b1;
            state_next = ST_OUT;
          end else begin
            state_next = ST_DISPATCH;
          end
        end
      end
      ST_DISPATCH: begin
        cur_key_next = rdata;
        slot_cnt_next = '0;
        priority if (req == loqe_pkg::REQ_CHILDREN) begin
          base_next = IW'(qidx);
          state_next = ST_CH_START;
        end else if (req == loqe_pkg::REQ_SIBLINGS) begin
          if (loqe_pkg::lvl_of(rdata) == '0) begin
            out_valid_next = 1'b1;
            slot_next = '0;
            found_next = 1'b0;
            result_index_next = '0;
            subtree_count_next = '0;
            status_next = loqe_pkg::STAT_ROOT;
            last_next = 1'b1;
            state_next = ST_OUT;
          end else begin
            needle_next = loqe_pkg::parent_key(rdata);
            lo_next = '0;
            hi_next = IW'(qidx);
            ret_next = ST_SIB_PAR;
            state_next = ST_SRCH;
          end
        end else begin
          if (qp1 < n && loqe_pkg::has_next(rdata)) begin
            raddr = AW'(qp1);
            state_next = ST_CHKN;
          end else begin
            state_next = ST_WALK;
          end
        end
      end
      ST_CH_START: begin
        raddr = AW'(c_idx);
        slot_cnt_next = '0;
        if (c_idx >= n) begin
          all_miss_next = 1'b1;
          state_next = ST_EMIT;
        end else begin
          state_next = ST_CH_CHK;
        end
      end
      ST_CH_CHK: begin
        if (!loqe_pkg::is_anc(cur_key, rdata)) begin
          all_miss_next = 1'b1;
        end else begin
          all_miss_next = 1'b0;
          cur_key_next = rdata;
          s0_next = loqe_pkg::slot_of(rdata);
        end
        state_next = ST_EMIT;
      end
      ST_SIB_PAR: begin
        raddr = AW'(s_idx);
        if (!s_found) begin
          all_miss_next = 1'b1;
          slot_cnt_next = '0;
          state_next = ST_EMIT;
        end else begin
          base_next = s_idx;
          state_next = ST_SIB_RDP;
        end
      end
      ST_SIB_RDP: begin
        cur_key_next = rdata;
        state_next = ST_CH_START;
      end
      ST_EMIT: begin
        slot_next = slot_cnt;
        subtree_count_next = '0;
        status_next = loqe_pkg::STAT_OK;
        last_next = (slot_cnt == loqe_pkg::SLOT_MAX);
        if (all_miss || slot_cnt < s0) begin
          out_valid_next = 1'b1;
          found_next = 1'b0;
          result_index_next = '0;
          state_next = ST_OUT;
        end else if (slot_cnt == s0) begin
          out_valid_next = 1'b1;
          found_next = 1'b1;
          result_index_next = XW'(c_idx);
          state_next = ST_OUT;
        end else begin
          cur_key_next = sib_key;
          needle_next = sib_key;
          lo_next = base;
          hi_next = n;
          ret_next = ST_EMIT_R;
          state_next = ST_SRCH;
        end
      end
      ST_EMIT_R: begin
        out_valid_next = 1'b1;
        found_next = s_found;
        result_index_next = s_found ? XW'(s_idx) : '0;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready) begin
          out_valid_next = 1'b0;
          if (last) begin
            state_next = ST_IDLE;
          end else begin
            slot_cnt_next = slot_cnt + 1'b1;
            state_next = ST_EMIT;
          end
        end
      end
      ST_CHKN: begin
        if (loqe_pkg::lvl_of(rdata) == loqe_pkg::lvl_of(cur_key)) begin
          out_valid_next = 1'b1;
          slot_next = '0;
          found_next = 1'b0;
          result_index_next = '0;
          subtree_count_next = '0;
          status_next = loqe_pkg::STAT_OK;
          last_next = 1'b1;
          state_next = ST_OUT;
        end else begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (loqe_pkg::lvl_of(cur_key) == '0) begin
          out_valid_next = 1'b1;
          slot_next = '0;
          found_next = 1'b0;
          result_index_next = '0;
          subtree_count_next = XW'(cnt_tail);
          status_next = loqe_pkg::STAT_OK;
          last_next = 1'b1;
          state_next = ST_OUT;
        end else if (loqe_pkg::has_next(cur_key)) begin
          cur_key_next = sib_key;
          needle_next = sib_key;
          lo_next = '0;
          hi_next = n;
          ret_next = ST_WALK_R;
          state_next = ST_SRCH;
        end else begin
          cur_key_next = loqe_pkg::parent_key(cur_key);
        end
      end
      ST_WALK_R: begin
        if (s_found) begin
          out_valid_next = 1'b1;
          slot_next = '0;
          found_next = 1'b0;
          result_index_next = '0;
          subtree_count_next = (s_idx > IW'(qidx)) ? XW'(s_idx - IW'(qidx) - 1'b1) : '0;
          status_next = loqe_pkg::STAT_OK;
          last_next = 1'b1;
          state_next = ST_OUT;
        end else if (loqe_pkg::has_next(cur_key)) begin
          cur_key_next = sib_key;
          needle_next = sib_key;
          lo_next = '0;
          hi_next = n;
          state_next = ST_SRCH;
        end else begin
          cur_key_next = loqe_pkg::parent_key(cur_key);
          state_next = ST_WALK;
        end
      end
      ST_SRCH: begin
        mid_next = lo + ((hi - 1'b1 - lo) >> 1);
        raddr = AW'(lo + ((hi - 1'b1 - lo) >> 1));
        if (lo < hi) begin
          state_next = ST_SCMP;
        end else begin
          s_found_next = 1'b0;
          state_next = ret;
        end
      end
      ST_SCMP: begin
        if (needle == rdata) begin
          s_found_next = 1'b1;
          s_idx_next = mid;
          state_next = ret;
        end else begin
          if (needle > rdata) begin
            lo_next = mid + 1'b1;
          end else begin
            hi_next = mid;
          end
          state_next = ST_SRCH;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
      eiu <= '0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
      if (cfg_we) begin
        eiu <= cfg_wdata;
      end
    end
    ret <= ret_next;
    req <= req_next;
    qidx <= qidx_next;
    n <= n_next;
    base <= base_next;
    lo <= lo_next;
    hi <= hi_next;
    mid <= mid_next;
    s_idx <= s_idx_next;
    s_found <= s_found_next;
    cur_key <= cur_key_next;
    needle <= needle_next;
    s0 <= s0_next;
    slot_cnt <= slot_cnt_next;
    all_miss <= all_miss_next;
    slot <= slot_next;
    found <= found_next;
    result_index <= result_index_next;
    subtree_count <= subtree_count_next;
    status <= status_next;
    last <= last_next;
  end

  `LOQE_ASSERT_NEXT(a_query_busy, in_valid && in_ready && req_type != loqe_pkg::REQ_LOAD, !in_ready, "query accepted but engine still ready")
  `LOQE_ASSERT_NOW(a_found_ok, out_valid && found, status == loqe_pkg::STAT_OK, "found result with error status")
  `LOQE_ASSERT_NEXT(a_more_results, out_valid && out_ready && !last, !in_ready, "new request taken before last result")

endmodule

/* test/tb_linear_octree_query_engine.sv */
// testbench for linear_octree_query_engine: loads octree key sets, runs children,
// siblings and subtree queries, checks every result against a predictor scoreboard
// depends on loqe_pkg and the linear_octree_query_engine rtl
module tb_linear_octree_query_engine;
  timeunit 1ns;
  timeprecision 1ps;

  typedef loqe_pkg::key_t key_t;

  typedef struct packed {
    logic [2:0] slot;
    logic       found;
    logic [9:0] ridx;
    logic [9:0] count;
    logic [1:0] stat;
    logic       last;
  } answer_t;

  class octree_scoreboard;
    key_t keys[1024];
    int unsigned used;
    answer_t answers[$];
    int errors;

    function new();
      used = 0;
      errors = 0;
      foreach (keys[i]) keys[i] = '0;
    endfunction

    function int lv(key_t k);
      return int'(k[3:0]);
    endfunction

    function key_t pth(key_t k);
      return k >> 4;
    endfunction

    function int shift_for(int l);
      return (l * 3 >= 60) ? 0 : 60 - l * 3;
    endfunction

    function int slot_at(key_t k);
      key_t t;
      t = pth(k) >> shift_for(lv(k));
      return (lv(k) == 0) ? 0 : int'(t[2:0]);
    endfunction

    function bit has_more(key_t k);
      return lv(k) > 0 && slot_at(k) < 7;
    endfunction

    function key_t sib_after(key_t k);
      int sh;
      key_t p;
      sh = shift_for(lv(k));
      p = pth(k) & ~(key_t'(7) << sh);
      p |= key_t'((slot_at(k) + 1) & 7) << sh;
      return (p << 4) | key_t'(lv(k));
    endfunction

    function key_t parent_of(key_t k);
      int pl, sh;
      pl = lv(k) > 0 ? lv(k) - 1 : 0;
      sh = shift_for(pl);
      return (((pth(k) >> sh) << sh) << 4) | key_t'(pl);
    endfunction

    function bit ancestor(key_t a, key_t d);
      return lv(a) < lv(d) && ((pth(a) ^ pth(d)) >> shift_for(lv(a))) == '0;
    endfunction

    function int locate(int lo, int hi, key_t needle);
      int cur;
      while (lo < hi) begin
        cur = lo + (hi - 1 - lo) / 2;
        if (needle == keys[cur]) return cur;
        if (needle > keys[cur]) lo = cur + 1;
        else hi = cur;
      end
      return -1;
    endfunction

    function void add(int s, int f, int ix, int cnt, logic [1:0] st, int lst);
      answer_t a;
      a.slot = s[2:0];
      a.found = f[0];
      a.ridx = f ? ix[9:0] : '0;
      a.count = cnt[9:0];
      a.stat = st;
      a.last = lst[0];
      answers.push_back(a);
    endfunction

    function void children(int p, int n);
      int c, s0, r;
      key_t k;
      c = p + 1;
      if (c >= n || !ancestor(keys[p], keys[c])) begin
        for (int s = 0; s < 8; s++) add(s, 0, 0, 0, loqe_pkg::STAT_OK, s == 7);
        return;
      end
      k = keys[c];
      s0 = slot_at(k);
      for (int s = 0; s < s0; s++) add(s, 0, 0, 0, loqe_pkg::STAT_OK, 0);
      add(s0, 1, c, 0, loqe_pkg::STAT_OK, s0 == 7);
      for (int s = s0 + 1; s < 8; s++) begin
        k = sib_after(k);
        r = locate(p, n, k);
        add(s, r >= 0, r, 0, loqe_pkg::STAT_OK, s == 7);
      end
    endfunction

    function int descendants(int idx, int n);
      key_t cur;
      int r;
      cur = keys[idx];
      if (idx + 1 < n && has_more(cur) && lv(keys[idx + 1]) == lv(cur)) return 0;
      while (lv(cur) > 0) begin
        if (has_more(cur)) begin
          do begin
            cur = sib_after(cur);
            r = locate(0, n, cur);
          end while (r < 0 && has_more(cur));
          if (r >= 0) return r > idx ? r - idx - 1 : 0;
        end
        cur = parent_of(cur);
      end
      return n - idx - 1;
    endfunction

    function void note_request(logic [1:0] req, int idx, key_t key);
      int n, p;
      if (req == loqe_pkg::REQ_LOAD) begin
        keys[idx] = key;
        return;
      end
      n = used > 1024 ? 1024 : used;
      if (idx >= n) begin
        add(0, 0, 0, 0, loqe_pkg::STAT_RANGE, 1);
      end else if (req == loqe_pkg::REQ_CHILDREN) begin
        children(idx, n);
      end else if (req == loqe_pkg::REQ_SIBLINGS) begin
        if (lv(keys[idx]) == 0) begin
          add(0, 0, 0, 0, loqe_pkg::STAT_ROOT, 1);
        end else begin
          p = locate(0, idx, parent_of(keys[idx]));
          if (p < 0) begin
            for (int s = 0; s < 8; s++) add(s, 0, 0, 0, loqe_pkg::STAT_OK, s == 7);
          end else begin
            children(p, n);
          end
        end
      end else begin
        add(0, 0, 0, descendants(idx, n), loqe_pkg::STAT_OK, 1);
      end
    endfunction

    function void check_result(answer_t got);
      answer_t e;
      if (answers.size() == 0) begin
        $error("unexpected result slot %0d status %0d", got.slot, got.stat);
        errors++;
        return;
      end
      e = answers.pop_front();
      if (got.slot !== e.slot) begin
        $error("slot expected %0d actual %0d", e.slot, got.slot); errors++;
      end
      if (got.found !== e.found) begin
        $error("found expected %0d actual %0d", e.found, got.found); errors++;
      end
      if (got.ridx !== e.ridx) begin
        $error("result_index expected %0d actual %0d", e.ridx, got.ridx); errors++;
      end
      if (got.count !== e.count) begin
        $error("subtree_count expected %0d actual %0d", e.count, got.count); errors++;
      end
      if (got.stat !== e.stat) begin
        $error("status expected %0d actual %0d", e.stat, got.stat); errors++;
      end
      if (got.last !== e.last) begin
        $error("last expected %0d actual %0d", e.last, got.last); errors++;
      end
    endfunction
  endclass

  logic clk, rst, cfg_we, in_valid, in_ready, out_valid, out_ready;
  logic [10:0] cfg_wdata;
  logic [1:0] req_type, status;
  logic [9:0] entry_index, result_index, subtree_count;
  logic [63:0] key_value;
  logic [2:0] slot;
  logic found, last;

  octree_scoreboard sb;
  key_t tree_q[$];
  bit tx_burst, rx_burst;
  int rx_hold;

  linear_octree_query_engine dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .req_type(req_type),
    .entry_index(entry_index), .key_value(key_value),
    .out_valid(out_valid), .out_ready(out_ready), .slot(slot), .found(found),
    .result_index(result_index), .subtree_count(subtree_count),
    .status(status), .last(last)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #40ms;
    $display("linear_octree_query_engine verification failed");
    $finish;
  end

  task automatic send(logic [1:0] req, int idx, key_t key);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= req;
    entry_index <= idx[9:0];
    key_value <= key;
    do @(posedge clk); while (!in_ready);
    sb.note_request(req, idx, key);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.answers.size() != 0) @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  task automatic set_count(int v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v[10:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.used = v;
  endtask

  function automatic void grow(key_t path, int lv, int depth, int cap, int pct, int top);
    tree_q.push_back((path << 4) | key_t'(lv));
    if (lv < depth)
      for (int s = 0; s < 8; s++)
        if ((lv > 0 || s < top) && $urandom_range(0, 99) < pct && tree_q.size() < cap)
          grow(path | (key_t'(s) << (60 - 3 * (lv + 1))), lv + 1, depth, cap, pct, top);
  endfunction

  task automatic load_set(int cap, int depth, int mode, bit pad);
    key_t k;
    tree_q.delete();
    if (mode == 0) begin
      grow('0, 0, depth, cap, 65, 8);
    end else begin
      repeat ($urandom_range(1, cap)) begin
        k = {$urandom, $urandom};
        if (mode == 2) k[3:0] = $urandom_range(0, 4);
        tree_q.push_back(k);
      end
      if ($urandom_range(0, 1)) tree_q.sort();
    end
    while (pad && tree_q.size() < cap) tree_q.push_back({$urandom, $urandom});
    set_count(tree_q.size());
    foreach (tree_q[i]) send(loqe_pkg::REQ_LOAD, i, tree_q[i]);
  endtask

  task automatic query_mix(int nq);
    int n;
    n = tree_q.size();
    repeat (nq) begin
      if ($urandom_range(0, 9) == 0)
        send(loqe_pkg::REQ_LOAD, int'($urandom_range(0, 1023)), {$urandom, $urandom});
      else if (n < 1024 && $urandom_range(0, 9) == 0)
        send(2'($urandom_range(1, 3)), int'($urandom_range(n, 1023)), {$urandom, $urandom});
      else
        send(2'($urandom_range(1, 3)), int'($urandom_range(0, n - 1)), {$urandom, $urandom});
    end
  endtask

  initial begin
    answer_t r;
    int stall;
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      stall = rx_hold > 0 ? rx_hold : (rx_burst ? 0 : $urandom_range(0, 19));
      rx_hold = 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      r.slot = slot;
      r.found = found;
      r.ridx = result_index;
      r.count = subtree_count;
      r.stat = status;
      r.last = last;
      sb.check_result(r);
    end
  end

  initial begin
    int n;
    sb = new();
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    req_type = loqe_pkg::REQ_LOAD;
    entry_index = '0;
    key_value = '0;
    tx_burst = 0;
    rx_burst = 0;
    rx_hold = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty store: everything out of range
    set_count(0);
    send(loqe_pkg::REQ_CHILDREN, 0, '0);
    send(loqe_pkg::REQ_SIBLINGS, 0, '0);
    send(loqe_pkg::REQ_SUBTREE, 1023, '0);

    // directed: small tree with no key for root slot 7, plus one level 2 key below that slot
    tree_q.delete();
    grow('0, 0, 3, 20, 60, 7);
    tree_q.push_back(((key_t'(7) << 57 | key_t'(3) << 54) << 4) | key_t'(2));
    set_count(tree_q.size());
    foreach (tree_q[i]) send(loqe_pkg::REQ_LOAD, i, tree_q[i]);
    n = tree_q.size();
    send(loqe_pkg::REQ_LOAD, 1023, '1);
    send(loqe_pkg::REQ_LOAD, 1022, '0);
    for (int t = 1; t < 4; t++) begin
      send(2'(t), 0, '0);
      send(2'(t), 1, '0);
      send(2'(t), n - 1, '0);
      send(2'(t), 1023, '0);
    end

    // random phases
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      tx_burst = $urandom_range(0, 3) == 0;
      rx_burst = $urandom_range(0, 3) == 0;
      load_set($urandom_range(2, 40), $urandom_range(1, 4),
               $urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0, 0);
      if (ph == 3) begin
        rx_hold = 400;
        tx_burst = 1;
      end
      query_mix(32);
    end

    // count register above, at and below the maximum, root keys at both ends
    tx_burst = 0;
    rx_burst = 0;
    drain();
    send(loqe_pkg::REQ_LOAD, 0, '0);
    send(loqe_pkg::REQ_LOAD, 1023, key_t'(5) << 60);
    for (int c = 0; c < 3; c++) begin
      set_count(c == 0 ? 2047 : (c == 1 ? 1024 : 1));
      send(loqe_pkg::REQ_SUBTREE, 0, '0);
      send(loqe_pkg::REQ_SUBTREE, 1023, '0);
      send(loqe_pkg::REQ_SIBLINGS, 1023, '0);
      send(loqe_pkg::REQ_CHILDREN, 1023, '0);
    end

    drain();
    if (sb.errors == 0 && sb.answers.size() == 0)
      $display("linear_octree_query_engine verification clean");
    else
      $display("linear_octree_query_engine verification failed");
    $finish;
  end
endmodule
